// File: src/wsp_pkg.sv
`timescale 1ns / 1ps

package wsp_pkg;

  localparam int WSP_SCAN_WINDOW = 64;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [9:0]  VOLUME_RESET = 10'd100;
  localparam logic [15:0] FMT_PCM      = 16'd1;
  localparam logic [15:0] BITS_WIDE    = 16'd16;

  // floor(m / 100) == (m * ceil(2^32 / 100)) >> 32 for every m below 2^30
  localparam logic [25:0] DIV100_RECIP = 26'd42949673;
  localparam int          DIV100_SHIFT = 32;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_INFO   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_TAGS    = 2'd0;
  localparam logic [1:0] ERR_NOT_PCM = 2'd1;
  localparam logic [1:0] ERR_NO_DATA = 2'd2;
  localparam logic [1:0] ERR_SHORT   = 2'd3;

  typedef enum logic [2:0] {
    OP_SAMPLE8,
    OP_SAMPLE16,
    OP_RAW,
    OP_INFO,
    OP_ERROR
  } wsp_op_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } wsp_in_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic signed [15:0] sample_value;
    logic              sample_wide;
    logic [15:0]       channel_count;
    logic [31:0]       rate_hz;
    logic [15:0]       bits_per_sample;
    logic [1:0]        error_code;
    logic              last;
  } wsp_out_t;

  // work item handed from the parser to the scaling pipeline
  typedef struct packed {
    wsp_op_t     op;
    logic [15:0] data;
    logic        last;
    logic [15:0] chan;
    logic [31:0] rate;
    logic [15:0] fbits;
    logic [1:0]  err;
  } wsp_cmd_t;

endpackage

// File: src/wsp_front.sv
`timescale 1ns / 1ps

module wsp_front
  import wsp_pkg::*;
#(
  parameter int SCAN_WINDOW = WSP_SCAN_WINDOW
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  wsp_in_t  in_data,
  output logic     in_stall,
  input  logic     q_full,
  output logic     push,
  output wsp_cmd_t push_cmd
);

  localparam int POS_W = ($clog2(SCAN_WINDOW + 5) > 6) ? $clog2(SCAN_WINDOW + 5) : 6;
  localparam logic [POS_W-1:0] WIN       = POS_W'(SCAN_WINDOW);
  localparam logic [POS_W-1:0] POS_RIFF  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_WAVE  = POS_W'(11);
  localparam logic [POS_W-1:0] POS_FMT   = POS_W'(15);
  localparam logic [POS_W-1:0] POS_CODE  = POS_W'(21);
  localparam logic [POS_W-1:0] POS_CHAN  = POS_W'(23);
  localparam logic [POS_W-1:0] POS_RATE  = POS_W'(27);
  localparam logic [POS_W-1:0] POS_BITS  = POS_W'(35);

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_SCAN   = 5'b00010,
    PH_SIZE   = 5'b00100,
    PH_DATA   = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      hdr_r, hdr_nxt;
  logic [31:0]      tag_r, tag_nxt;
  logic [15:0]      fbits_r, fbits_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic             hold_v_r, hold_v_nxt;
  logic [7:0]       hold_b_r, hold_b_nxt;
  logic             tags_bad_r, tags_bad_nxt;
  logic             not_pcm_r, not_pcm_nxt;
  logic [15:0]      chan_r, chan_nxt;
  logic [31:0]      rate_r, rate_nxt;
  logic [1:0]       sidx_r, sidx_nxt;

  logic             accept;
  logic [7:0]       b;
  logic             eof;
  logic [31:0]      hdr_shift;
  logic [31:0]      tag_shift;
  logic [POS_W-1:0] pos_inc;
  logic [31:0]      rem_dec;
  logic [31:0]      rem_sz;
  logic             fin;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign b         = in_data.data_byte;
  assign eof       = in_data.end_of_file;
  assign hdr_shift = {b, hdr_r[31:8]};
  assign tag_shift = {b, tag_r[31:8]};
  assign pos_inc   = pos_r + 1'b1;
  assign rem_dec   = rem_r - 32'd1;
  assign fin       = (rem_dec == 32'd0) || eof;

  always_comb begin
    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    hdr_nxt      = hdr_r;
    tag_nxt      = tag_r;
    fbits_nxt    = fbits_r;
    rem_nxt      = rem_r;
    hold_v_nxt   = hold_v_r;
    hold_b_nxt   = hold_b_r;
    tags_bad_nxt = tags_bad_r;
    not_pcm_nxt  = not_pcm_r;
    chan_nxt     = chan_r;
    rate_nxt     = rate_r;
    sidx_nxt     = sidx_r;
    rem_sz       = rem_r;
    push         = 1'b0;
    push_cmd     = '0;
    push_cmd.op  = OP_ERROR;

    if (accept) begin
      unique case (phase_r)
        PH_HEADER: begin
          hdr_nxt = hdr_shift;
          if (pos_r == POS_RIFF && hdr_shift != TAG_RIFF) tags_bad_nxt = 1'b1;
          if (pos_r == POS_WAVE && hdr_shift != TAG_WAVE) tags_bad_nxt = 1'b1;
          if (pos_r == POS_FMT && hdr_shift != TAG_FMT) tags_bad_nxt = 1'b1;
          if (pos_r == POS_CODE && hdr_shift[31:16] != FMT_PCM) not_pcm_nxt = 1'b1;
          if (pos_r == POS_CHAN) chan_nxt = hdr_shift[31:16];
          if (pos_r == POS_RATE) rate_nxt = hdr_shift;
          if (pos_r == POS_BITS) fbits_nxt = hdr_shift[31:16];
          if (pos_r == POS_BITS) begin
            push = 1'b1;
            if (tags_bad_r || not_pcm_r || eof) begin
              push_cmd.op  = OP_ERROR;
              push_cmd.err = tags_bad_r ? ERR_TAGS : (not_pcm_r ? ERR_NOT_PCM : ERR_NO_DATA);
              phase_nxt    = PH_DONE;
            end else begin
              push_cmd.op    = OP_INFO;
              push_cmd.chan  = chan_r;
              push_cmd.rate  = rate_r;
              push_cmd.fbits = hdr_shift[31:16];
              phase_nxt      = PH_SCAN;
              pos_nxt        = '0;
              tag_nxt        = '0;
            end
          end else if (eof) begin
            push         = 1'b1;
            push_cmd.op  = OP_ERROR;
            push_cmd.err = ERR_SHORT;
          end else begin
            pos_nxt = pos_inc;
          end
        end
        PH_SCAN: begin
          tag_nxt = tag_shift;
          pos_nxt = pos_inc;
          if (tag_shift == TAG_DATA) begin
            phase_nxt = PH_SIZE;
            sidx_nxt  = '0;
            rem_nxt   = '0;
          end else if (pos_inc >= WIN || eof) begin
            push         = 1'b1;
            push_cmd.op  = OP_ERROR;
            push_cmd.err = ERR_NO_DATA;
            phase_nxt    = PH_DONE;
          end
        end
        PH_SIZE: begin
          // size bytes past the scan window read as zero
          if (pos_r < WIN) rem_sz = rem_r | ({24'b0, b} << {sidx_r, 3'b000});
          rem_nxt  = rem_sz;
          pos_nxt  = pos_inc;
          sidx_nxt = sidx_r + 2'd1;
          if (sidx_r == 2'd3) begin
            if (rem_sz == 32'd0 || rem_sz[31]) begin
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt  = PH_DATA;
              hold_v_nxt = 1'b0;
            end
          end
        end
        PH_DATA: begin
          rem_nxt = rem_dec;
          if (fbits_r == BITS_WIDE && !hold_v_r) begin
            if (fin) begin
              // odd trailing low byte goes out as is
              push          = 1'b1;
              push_cmd.op   = OP_RAW;
              push_cmd.data = {8'b0, b};
              push_cmd.last = 1'b1;
              phase_nxt     = PH_DONE;
            end else begin
              hold_b_nxt = b;
              hold_v_nxt = 1'b1;
            end
          end else begin
            push = 1'b1;
            if (fbits_r == BITS_WIDE) begin
              push_cmd.op   = OP_SAMPLE16;
              push_cmd.data = {b, hold_b_r};
              hold_v_nxt    = 1'b0;
            end else begin
              push_cmd.op   = OP_SAMPLE8;
              push_cmd.data = {8'b0, b};
            end
            if (fin) begin
              push_cmd.last = 1'b1;
              phase_nxt     = PH_DONE;
            end
          end
        end
        PH_DONE: begin
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase

      if (eof) begin
        phase_nxt    = PH_HEADER;
        pos_nxt      = '0;
        hdr_nxt      = '0;
        tag_nxt      = '0;
        fbits_nxt    = '0;
        rem_nxt      = '0;
        hold_v_nxt   = 1'b0;
        hold_b_nxt   = '0;
        tags_bad_nxt = 1'b0;
        not_pcm_nxt  = 1'b0;
        chan_nxt     = '0;
        rate_nxt     = '0;
        sidx_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      pos_r      <= '0;
      hdr_r      <= '0;
      tag_r      <= '0;
      fbits_r    <= '0;
      rem_r      <= '0;
      hold_v_r   <= 1'b0;
      hold_b_r   <= '0;
      tags_bad_r <= 1'b0;
      not_pcm_r  <= 1'b0;
      chan_r     <= '0;
      rate_r     <= '0;
      sidx_r     <= '0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      hdr_r      <= hdr_nxt;
      tag_r      <= tag_nxt;
      fbits_r    <= fbits_nxt;
      rem_r      <= rem_nxt;
      hold_v_r   <= hold_v_nxt;
      hold_b_r   <= hold_b_nxt;
      tags_bad_r <= tags_bad_nxt;
      not_pcm_r  <= not_pcm_nxt;
      chan_r     <= chan_nxt;
      rate_r     <= rate_nxt;
      sidx_r     <= sidx_nxt;
    end
  end

endmodule

// File: src/wsp_queue.sv
`timescale 1ns / 1ps

module wsp_queue
  import wsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  wsp_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output wsp_cmd_t head_cmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  wsp_cmd_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
    else $error("queue read while empty");

endmodule

// File: src/wsp_scale.sv
`timescale 1ns / 1ps

module wsp_scale
  import wsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic [9:0] volume,
  input  logic     head_valid,
  input  wsp_cmd_t head_cmd,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_stall,
  output wsp_out_t out_data
);

  logic               en;
  logic signed [16:0] opnd;
  logic signed [27:0] prod;
  logic [27:0]        mag;
  logic [50:0]        quot_full;
  logic signed [19:0] qs;
  logic [15:0]        wide_val;
  logic [7:0]         narrow_val;
  wsp_out_t           res;

  logic               s1_valid_r;
  wsp_cmd_t           s1_cmd_r;
  logic signed [27:0] s1_prod_r;
  logic               s2_valid_r;
  wsp_cmd_t           s2_cmd_r;
  logic               s2_neg_r;
  logic [18:0]        s2_q_r;
  logic               out_valid_r;
  wsp_out_t           out_data_r;

  // whole pipe advances unless a finished result is held back
  assign en  = !out_valid_r || !out_stall;
  assign pop = en && head_valid;

  always_comb begin
    unique case (head_cmd.op)
      OP_SAMPLE16: opnd = {head_cmd.data[15], head_cmd.data};
      OP_SAMPLE8:  opnd = $signed({9'b0, head_cmd.data[7:0]}) - 17'sd128;
      default:     opnd = '0;
    endcase
    prod = opnd * $signed({1'b0, volume});
  end

  // divide by 100 on the magnitude so the quotient truncates toward zero
  assign mag       = s1_prod_r[27] ? 28'(-s1_prod_r) : 28'(s1_prod_r);
  assign quot_full = mag[24:0] * DIV100_RECIP;

  always_comb begin
    qs = s2_neg_r ? -$signed({1'b0, s2_q_r}) : $signed({1'b0, s2_q_r});
    if (qs > 20'sd32767)       wide_val = 16'h7fff;
    else if (qs < -20'sd32767) wide_val = 16'h8001;
    else                       wide_val = qs[15:0];
    narrow_val = qs[7:0] + 8'd128;

    res      = '0;
    res.last = s2_cmd_r.last;
    unique case (s2_cmd_r.op)
      OP_SAMPLE16: begin
        res.result_kind  = KIND_SAMPLE;
        res.sample_value = wide_val;
        res.sample_wide  = 1'b1;
      end
      OP_SAMPLE8: begin
        res.result_kind  = KIND_SAMPLE;
        res.sample_value = {8'b0, narrow_val};
      end
      OP_RAW: begin
        res.result_kind  = KIND_SAMPLE;
        res.sample_value = {8'b0, s2_cmd_r.data[7:0]};
      end
      OP_INFO: begin
        res.result_kind     = KIND_INFO;
        res.channel_count   = s2_cmd_r.chan;
        res.rate_hz         = s2_cmd_r.rate;
        res.bits_per_sample = s2_cmd_r.fbits;
      end
      OP_ERROR: begin
        res.result_kind = KIND_ERROR;
        res.error_code  = s2_cmd_r.err;
      end
      default: begin
        res.result_kind = KIND_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= head_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd_r   <= head_cmd;
      s1_prod_r  <= prod;
      s2_cmd_r   <= s1_cmd_r;
      s2_neg_r   <= s1_prod_r[27];
      s2_q_r     <= quot_full[DIV100_SHIFT +: 19];
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_narrow_range: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_data_r.result_kind == KIND_SAMPLE && !out_data_r.sample_wide)
      |-> (out_data_r.sample_value[15:8] == 8'd0))
    else $error("8-bit sample exceeds one byte");
  a_wide_clamp: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_data_r.sample_wide)
      |-> (out_data_r.sample_value != 16'sh8000 && out_data_r.result_kind == KIND_SAMPLE))
    else $error("wide sample outside clamp range");
  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
      (s2_valid_r && !en) |=> (s2_valid_r && $stable(s2_q_r)))
    else $error("pipeline stage lost while output stalled");

endmodule

// File: src/wav_stream_parser_volume_unit.sv
`timescale 1ns / 1ps

// channel   ports                               item
// input     in_valid, in_stall, in_data         one file byte, end-of-file flag
// result    out_valid, out_stall, out_data      sample, format info or error
// config    cfg_we, cfg_wdata                   volume in percent (reset 100)
//
// One byte is taken per cycle while in_stall is low; the parser handles a byte in the cycle it is taken.
// A result leaves the queue and passes the stages: multiply off the queue head,
// reciprocal divide by 100, then clamp and pack into the output register.
// in_stall rises only when the 4-entry queue is full, i.e. after out_stall backs it up.
// Synchronous active-low reset; no clearing pass, the block takes bytes right after it.
// Volume is sampled live by the multiplier; change it only while the block is idle.

module wav_stream_parser_volume_unit
  import wsp_pkg::*;
#(
  parameter int SCAN_WINDOW = WSP_SCAN_WINDOW
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  wsp_in_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output wsp_out_t   out_data,
  input  logic       cfg_we,
  input  logic [9:0] cfg_wdata
);

  logic [9:0] volume_r;
  logic       q_full;
  logic       push;
  wsp_cmd_t   push_cmd;
  logic       pop;
  logic       head_valid;
  wsp_cmd_t   head_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r <= VOLUME_RESET;
    end else if (cfg_we) begin
      volume_r <= cfg_wdata;
    end
  end

  wsp_front #(
    .SCAN_WINDOW (SCAN_WINDOW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  wsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  wsp_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .volume     (volume_r),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
